[rtl/qvr_pkg.sv]
// Package for the quaternion vector rotation unit: payload types and widths.
package qvr_pkg;

  localparam int QUO_W = 16;               // quotient bits resolved by the divider
  localparam int DEN_W = 34;               // twice the squared norm
  localparam int REM_W = 51;               // numerator and partial remainder
  localparam int DIV_STAGES = QUO_W + 1;   // range check stage plus one per bit

  typedef struct packed {
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_real;
    logic signed [15:0] vec_x;
    logic signed [15:0] vec_y;
    logic signed [15:0] vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic               clipped;
    logic               zero_norm;
  } qvr_out_t;

  // Side information that rides along with each divider lane
  typedef struct packed {
    logic neg;
    logic zero_norm;
  } qvr_tag_t;

endpackage

[rtl/qvr_div.sv]
// Pipelined restoring divider lane: one quotient bit per stage, with range check.
module qvr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [qvr_pkg::REM_W-1:0]   num,
  input  logic [qvr_pkg::DEN_W-1:0]   den,
  input  qvr_pkg::qvr_tag_t           in_tag,
  output logic                        out_valid,
  output logic [qvr_pkg::QUO_W-1:0]   quo,
  output logic                        ovf,
  output qvr_pkg::qvr_tag_t           out_tag
);

  localparam int N = qvr_pkg::DIV_STAGES;

  logic                        vld   [N];
  logic [qvr_pkg::REM_W-1:0]   rem   [N];
  logic [qvr_pkg::DEN_W-1:0]   dsr   [N];
  logic [qvr_pkg::QUO_W-1:0]   qb    [N];
  logic                        big   [N];
  qvr_pkg::qvr_tag_t           tag   [N];

  // Entry: flag quotients that cannot fit in the bits resolved below
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0] <= num;
    dsr[0] <= den;
    qb[0]  <= '0;
    big[0] <= (num >= {1'b0, den, {qvr_pkg::QUO_W{1'b0}}});
    tag[0] <= in_tag;
  end

  for (genvar k = 1; k < N; k++) begin : g_step
    localparam int B = N - 1 - k;
    logic [qvr_pkg::REM_W-1:0] trial;
    logic                      take;

    assign trial = qvr_pkg::REM_W'(dsr[k-1]) << B;
    assign take  = (rem[k-1] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rem[k]    <= take ? (rem[k-1] - trial) : rem[k-1];
      dsr[k]    <= dsr[k-1];
      qb[k]     <= qb[k-1] | (qvr_pkg::QUO_W'(take) << B);
      big[k]    <= big[k-1];
      tag[k]    <= tag[k-1];
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = qb[N-1];
  assign ovf       = big[N-1];
  assign out_tag   = tag[N-1];

endmodule

[rtl/quaternion_vector_rotate_unit.sv]
// Top level of the quaternion vector rotation unit.
// Usage:
//   Drive cmd and raise start; a transaction is taken at each rising edge with
//   start high and busy low. busy is always low, so a new transaction may be
//   issued every cycle and many are in flight at once.
//   Each result appears on result for one cycle with done high, in issue
//   order. The receiver cannot stall the block and must take results as
//   they come.
//   Throughput is one transaction per cycle. The path runs through five
//   arithmetic stages (products, sums, wide products, final sum, magnitude)
//   followed by the 17-stage divider (range check plus one quotient bit per
//   stage) and the output register.
//   Results are rounded to nearest, halves away from zero, and saturated
//   with clipped set; a zero quaternion returns zeros with zero_norm set.
//   Synchronous reset drops every transaction in flight; no result follows.
module quaternion_vector_rotate_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qvr_pkg::qvr_in_t  cmd,
  output logic              done,
  output qvr_pkg::qvr_out_t result
);

  assign busy = 1'b0;

  // Stage 1: 16x16 products
  logic v1, z1;
  logic signed [31:0] ii, jj, kk, ww, ix, jy, kz, jz, ky, kx, iz, iy, jx;
  logic signed [15:0] ui1, uj1, uk1, w1, vx1, vy1, vz1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
    z1  <= (cmd.quat_i == '0) && (cmd.quat_j == '0) && (cmd.quat_k == '0) &&
           (cmd.quat_real == '0);
    ii  <= cmd.quat_i * cmd.quat_i;
    jj  <= cmd.quat_j * cmd.quat_j;
    kk  <= cmd.quat_k * cmd.quat_k;
    ww  <= cmd.quat_real * cmd.quat_real;
    ix  <= cmd.quat_i * cmd.vec_x;
    jy  <= cmd.quat_j * cmd.vec_y;
    kz  <= cmd.quat_k * cmd.vec_z;
    jz  <= cmd.quat_j * cmd.vec_z;
    ky  <= cmd.quat_k * cmd.vec_y;
    kx  <= cmd.quat_k * cmd.vec_x;
    iz  <= cmd.quat_i * cmd.vec_z;
    iy  <= cmd.quat_i * cmd.vec_y;
    jx  <= cmd.quat_j * cmd.vec_x;
    ui1 <= cmd.quat_i;
    uj1 <= cmd.quat_j;
    uk1 <= cmd.quat_k;
    w1  <= cmd.quat_real;
    vx1 <= cmd.vec_x;
    vy1 <= cmd.vec_y;
    vz1 <= cmd.vec_z;
  end

  // Stage 2: norm, scalar terms, dot and cross products
  logic v2, z2;
  logic signed [33:0] uu_c;
  logic [32:0]        n2;
  logic signed [33:0] a2, uv2, cx2, cy2, cz2;
  logic signed [15:0] ui2, uj2, uk2, w2, vx2, vy2, vz2;

  assign uu_c = 34'(ii) + 34'(jj) + 34'(kk);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    z2  <= z1;
    n2  <= 33'(uu_c + 34'(ww));
    a2  <= 34'(ww) - uu_c;
    uv2 <= 34'(ix) + 34'(jy) + 34'(kz);
    cx2 <= 34'(jz) - 34'(ky);
    cy2 <= 34'(kx) - 34'(iz);
    cz2 <= 34'(iy) - 34'(jx);
    ui2 <= ui1; uj2 <= uj1; uk2 <= uk1; w2 <= w1;
    vx2 <= vx1; vy2 <= vy1; vz2 <= vz1;
  end

  // Stage 3: wide products
  logic v3, z3;
  logic [32:0]        n3;
  logic signed [49:0] ax, ay, az, ux, uy, uz, wx, wy, wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    z3 <= z2;
    n3 <= n2;
    ax <= a2 * vx2;
    ay <= a2 * vy2;
    az <= a2 * vz2;
    ux <= uv2 * ui2;
    uy <= uv2 * uj2;
    uz <= uv2 * uk2;
    wx <= cx2 * w2;
    wy <= cy2 * w2;
    wz <= cz2 * w2;
  end

  // Stage 4: numerators
  logic v4, z4;
  logic [32:0]        n4;
  logic signed [49:0] px, py, pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    z4 <= z3;
    n4 <= n3;
    px <= ax + (ux <<< 1) + (wx <<< 1);
    py <= ay + (uy <<< 1) + (wy <<< 1);
    pz <= az + (uz <<< 1) + (wz <<< 1);
  end

  // Stage 5: sign and rounding offset, so the divider works on magnitudes
  logic v5;
  logic [qvr_pkg::DEN_W-1:0] d5;
  logic [qvr_pkg::REM_W-1:0] nx5, ny5, nz5;
  qvr_pkg::qvr_tag_t         tx5, ty5, tz5;
  logic [49:0] mx, my, mz;

  assign mx = px[49] ? 50'(-px) : 50'(px);
  assign my = py[49] ? 50'(-py) : 50'(py);
  assign mz = pz[49] ? 50'(-pz) : 50'(pz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    d5  <= {n4, 1'b0};
    nx5 <= {mx, 1'b0} + qvr_pkg::REM_W'(n4);
    ny5 <= {my, 1'b0} + qvr_pkg::REM_W'(n4);
    nz5 <= {mz, 1'b0} + qvr_pkg::REM_W'(n4);
    tx5 <= '{neg: px[49], zero_norm: z4};
    ty5 <= '{neg: py[49], zero_norm: z4};
    tz5 <= '{neg: pz[49], zero_norm: z4};
  end

  // Divider lanes
  logic                      dvx, dvy, dvz;
  logic [qvr_pkg::QUO_W-1:0] qx, qy, qz;
  logic                      ox, oy, oz;
  qvr_pkg::qvr_tag_t         tgx, tgy, tgz;

  qvr_div u_div_x (
    .clk(clk), .rst(rst), .in_valid(v5), .num(nx5), .den(d5), .in_tag(tx5),
    .out_valid(dvx), .quo(qx), .ovf(ox), .out_tag(tgx)
  );
  qvr_div u_div_y (
    .clk(clk), .rst(rst), .in_valid(v5), .num(ny5), .den(d5), .in_tag(ty5),
    .out_valid(dvy), .quo(qy), .ovf(oy), .out_tag(tgy)
  );
  qvr_div u_div_z (
    .clk(clk), .rst(rst), .in_valid(v5), .num(nz5), .den(d5), .in_tag(tz5),
    .out_valid(dvz), .quo(qz), .ovf(oz), .out_tag(tgz)
  );

  // Apply sign and clamp to the 16-bit range; bit 16 of the result is the clip flag
  function automatic logic [16:0] sat_lane(input logic [15:0] q, input logic big,
                                           input logic neg);
    logic [16:0] r;
    if (neg) begin
      if (big || (q > 16'd32768)) begin
        r = {1'b1, 16'h8000};
      end else begin
        r = {1'b0, 16'(-q)};
      end
    end else begin
      if (big || (q > 16'd32767)) begin
        r = {1'b1, 16'h7FFF};
      end else begin
        r = {1'b0, q};
      end
    end
    return r;
  endfunction

  logic [16:0] sx, sy, sz;
  logic        zn;

  assign sx = sat_lane(qx, ox, tgx.neg);
  assign sy = sat_lane(qy, oy, tgy.neg);
  assign sz = sat_lane(qz, oz, tgz.neg);
  assign zn = tgx.zero_norm;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dvx & dvy & dvz;
    end
    if (zn) begin
      result <= '{rot_x: '0, rot_y: '0, rot_z: '0, clipped: 1'b0, zero_norm: 1'b1};
    end else begin
      result.rot_x     <= sx[15:0];
      result.rot_y     <= sy[15:0];
      result.rot_z     <= sz[15:0];
      result.clipped   <= sx[16] | sy[16] | sz[16];
      result.zero_norm <= 1'b0;
    end
  end

endmodule

[test/testbench.sv]
// Testbench for the quaternion vector rotation unit: directed and random rotations.
`timescale 1ns / 1ps

module testbench;

  class rotation_scoreboard;
    qvr_pkg::qvr_out_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    // Round num / den to nearest, halves away from zero, then saturate
    function automatic logic signed [15:0] div_sat(longint num, longint den, ref bit sat);
      longint mag;
      longint q;
      mag = num < 0 ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (num < 0) begin
        if (q > 32768) begin
          sat = 1;
          return -16'sd32768;
        end
        return -q;
      end
      if (q > 32767) begin
        sat = 1;
        return 16'sd32767;
      end
      return q;
    endfunction

    function void note_cmd(qvr_pkg::qvr_in_t c);
      longint ux, uy, uz, w, vx, vy, vz, uu, n, a, uv, cx, cy, cz;
      qvr_pkg::qvr_out_t r;
      bit sat;
      ux = c.quat_i; uy = c.quat_j; uz = c.quat_k; w = c.quat_real;
      vx = c.vec_x; vy = c.vec_y; vz = c.vec_z;
      uu = ux * ux + uy * uy + uz * uz;
      n = uu + w * w;
      r = '0;
      sat = 0;
      if (n == 0) begin
        r.zero_norm = 1;
      end else begin
        a = w * w - uu;
        uv = ux * vx + uy * vy + uz * vz;
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        r.rot_x = div_sat(a * vx + 2 * uv * ux + 2 * w * cx, n, sat);
        r.rot_y = div_sat(a * vy + 2 * uv * uy + 2 * w * cy, n, sat);
        r.rot_z = div_sat(a * vz + 2 * uv * uz + 2 * w * cz, n, sat);
        r.clipped = sat;
      end
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(qvr_pkg::qvr_out_t got);
      qvr_pkg::qvr_out_t want;
      if (pending.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.rot_x !== want.rot_x)
        report($sformatf("rot_x got %0d want %0d", got.rot_x, want.rot_x));
      if (got.rot_y !== want.rot_y)
        report($sformatf("rot_y got %0d want %0d", got.rot_y, want.rot_y));
      if (got.rot_z !== want.rot_z)
        report($sformatf("rot_z got %0d want %0d", got.rot_z, want.rot_z));
      if (got.clipped !== want.clipped)
        report($sformatf("clipped got %b want %b", got.clipped, want.clipped));
      if (got.zero_norm !== want.zero_norm)
        report($sformatf("zero_norm got %b want %b", got.zero_norm, want.zero_norm));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic done;
  qvr_pkg::qvr_in_t cmd = '0;
  qvr_pkg::qvr_out_t result;
  rotation_scoreboard sb = new();

  quaternion_vector_rotate_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'h4000;
      4: return 16'hc000;
      5: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Hold start until the transaction is taken, then optionally idle
  task send_cmd(qvr_pkg::qvr_in_t c, int gap);
    cmd <= c;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_cmd(c);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic qvr_pkg::qvr_in_t random_cmd();
    qvr_pkg::qvr_in_t c;
    c.quat_i = pick_field(); c.quat_j = pick_field();
    c.quat_k = pick_field(); c.quat_real = pick_field();
    c.vec_x = pick_field(); c.vec_y = pick_field(); c.vec_z = pick_field();
    return c;
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  initial begin
    qvr_pkg::qvr_in_t c;
    int burst;
    int waited;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: identity, zero quaternion, full-scale corners, axis turns
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd1000, -16'sd2000, 16'sd3000};
    send_cmd(c, 0);
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1234, 16'sd5, -16'sd7};
    send_cmd(c, 0);
    c = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
          -16'sd32768, -16'sd32768, -16'sd32768};
    send_cmd(c, 0);
    c = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
          16'sd32767, 16'sd32767, 16'sd32767};
    send_cmd(c, 2);
    c = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd1, 16'sd32767, -16'sd32768, 16'sd32767};
    send_cmd(c, 0);
    c = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'sd0, 16'sd32767, -16'sd32768};
    send_cmd(c, 0);
    c = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd1};
    send_cmd(c, 0);
    c = '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd3, 16'sd3, 16'sd3};
    send_cmd(c, 0);
    // Tiny norm with big vector: results land at full scale without clipping
    c = '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd100};
    send_cmd(c, 1);
    // Norm 4 scale with small vectors
    c = '{16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd1, -16'sd1, 16'sd3};
    send_cmd(c, 0);
    c = '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd0, -16'sd1};
    send_cmd(c, 0);
    for (int i = 0; i < 1850; i++) begin
      if (i == 900) begin
        // Drain the pipeline before carrying on
        start <= 0;
        waited = 0;
        while (sb.pending.size() != 0 && waited < 200) begin
          @(posedge clk);
          waited++;
        end
      end
      burst = $urandom_range(0, 7);
      send_cmd(random_cmd(), (burst == 0) ? draw_gap() : 0);
    end
    start <= 0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.pending.size() != 0) sb.report("transactions left without a result");
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
